// File: src/id3v2_text_frame_extractor_defines.svh
`ifndef ID3V2_TEXT_FRAME_EXTRACTOR_DEFINES_SVH
`define ID3V2_TEXT_FRAME_EXTRACTOR_DEFINES_SVH

// property checked only while out of reset
`define ID3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ID3_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/id3_pkg.sv
package id3_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int HDR_BYTES        = 10;
    localparam int SYNCSAFE_VERSION = 4;

    localparam logic [31:0] ID_TITLE  = 32'h5449_5432;
    localparam logic [31:0] ID_ARTIST = 32'h5450_4531;
    localparam logic [31:0] ID_ALBUM  = 32'h5441_4C42;
    localparam logic [31:0] ID_TRACK  = 32'h5452_434B;

    localparam logic [2:0] KIND_TITLE  = 3'd0;
    localparam logic [2:0] KIND_ARTIST = 3'd1;
    localparam logic [2:0] KIND_ALBUM  = 3'd2;
    localparam logic [2:0] KIND_TRACK  = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;
    localparam logic [2:0] KIND_NONE   = 3'd7;

    // one queued job: an optional text result, then an optional done result
    typedef struct packed {
        logic        has_text;
        logic        has_done;
        logic [1:0]  text_kind;
        logic [7:0]  text_byte;
        logic        last;
        logic [28:0] offset;
    } t_entry;

    function automatic logic [2:0] frame_kind(input logic [31:0] ident);
        logic [2:0] kind;
        kind = KIND_NONE;
        if (ident == ID_TITLE) kind = KIND_TITLE;
        else if (ident == ID_ARTIST) kind = KIND_ARTIST;
        else if (ident == ID_ALBUM) kind = KIND_ALBUM;
        else if (ident == ID_TRACK) kind = KIND_TRACK;
        return kind;
    endfunction

endpackage

// File: src/id3v2_text_frame_extractor.sv
// path: a result is held in the job queue, then in the output register driving m_axis
// throughput: one byte per cycle while the queue has room; output one result per cycle
// when m_axis is ready, so the byte that ends a text frame at the tag end needs two
// output transfers, absorbed by the job queue. reset: synchronous, active low; parser back
// to the header phase, queue and output register emptied
module id3v2_text_frame_extractor #(
    parameter int QUEUE_DEPTH = id3_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] text_byte, [36:8] audio_offset, [39:37] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] item_kind
    output logic        m_axis_tlast    // last_in_field
);

    id3_pkg::t_entry push_entry, head_entry;
    logic            push, room, head_valid, pop;
    logic [7:0]      out_text;
    logic [28:0]     out_offset;

    id3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_start (s_axis_tuser),
        .i_room  (room),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    id3_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_room  (room),
        .o_valid (head_valid),
        .o_entry (head_entry),
        .i_pop   (pop)
    );

    id3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (m_axis_tuser),
        .o_text   (out_text),
        .o_last   (m_axis_tlast),
        .o_offset (out_offset)
    );

    assign m_axis_tdata = {3'b000, out_offset, out_text};

endmodule

// File: src/id3_front.sv
module id3_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data,
    input  logic                i_start,
    input  logic                i_room,
    output logic                o_ready,
    output logic                o_push,
    output id3_pkg::t_entry     o_entry
);

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_FRAME_HDR = 3'd1;
    localparam logic [2:0] PH_ENCODING  = 3'd2;
    localparam logic [2:0] PH_BODY      = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [28:0] r_tag, n_tag;
    logic [32:0] r_consumed, n_consumed;
    logic [32:0] r_sum, n_sum;
    logic        r_reached, n_reached;
    logic [31:0] r_ident, n_ident;
    logic [31:0] r_frame_len, n_frame_len;
    logic [31:0] r_rem, n_rem;
    logic        r_sync, n_sync;
    logic        r_sel_hit, n_sel_hit;
    logic [1:0]  r_sel_kind, n_sel_kind;

    logic        accept;
    logic [2:0]  phase_eff;
    logic [3:0]  cnt_eff;
    logic        bnd;
    logic        reached;
    logic [31:0] len_base;
    logic [2:0]  kind_lookup;

    assign o_ready     = i_room;
    assign accept      = i_valid & i_room;
    assign kind_lookup = id3_pkg::frame_kind(r_ident);

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_tag       = r_tag;
        n_consumed  = r_consumed;
        n_sum       = r_sum;
        n_reached   = r_reached;
        n_ident     = r_ident;
        n_frame_len = r_frame_len;
        n_rem       = r_rem;
        n_sync      = r_sync;
        n_sel_hit   = r_sel_hit;
        n_sel_kind  = r_sel_kind;
        o_push      = 1'b0;
        o_entry     = '0;
        bnd         = 1'b0;
        reached     = r_reached;
        len_base    = (r_cnt == 4'd4) ? 32'd0 : r_frame_len;
        // a start byte is always header byte 0
        phase_eff   = i_start ? PH_HEADER : r_phase;
        cnt_eff     = i_start ? 4'd0 : r_cnt;

        if (accept) begin
            n_phase = phase_eff;
            n_cnt   = cnt_eff;
            unique case (phase_eff)
                PH_HEADER: begin
                    if (cnt_eff == 4'd3)
                        n_sync = (i_data == 8'(id3_pkg::SYNCSAFE_VERSION));
                    if (cnt_eff == 4'd6)
                        n_tag = {22'd0, i_data[6:0]};
                    else if (cnt_eff > 4'd6)
                        n_tag = {r_tag[21:0], i_data[6:0]};
                    if (cnt_eff == 4'(id3_pkg::HDR_BYTES - 1)) begin
                        n_consumed = '0;
                        reached    = (n_tag == '0);
                        n_reached  = reached;
                        bnd        = 1'b1;
                    end else begin
                        n_cnt = cnt_eff + 4'd1;
                    end
                end
                PH_FRAME_HDR: begin
                    if (cnt_eff < 4'd4) begin
                        n_ident = {r_ident[23:0], i_data};
                    end else if (cnt_eff < 4'd8) begin
                        if (r_sync)
                            n_frame_len = {len_base[24:0], i_data[6:0]};
                        else
                            n_frame_len = {len_base[23:0], i_data};
                    end else if (cnt_eff == 4'd8) begin
                        // size is complete by now; sum ahead of the boundary byte
                        n_sum = r_consumed + {1'b0, r_frame_len}
                              + 33'(id3_pkg::HDR_BYTES);
                    end
                    if (cnt_eff == 4'(id3_pkg::HDR_BYTES - 1)) begin
                        n_consumed = r_sum;
                        reached    = (r_sum >= {4'd0, r_tag});
                        n_reached  = reached;
                        n_sel_hit  = (kind_lookup != id3_pkg::KIND_NONE);
                        n_sel_kind = kind_lookup[1:0];
                        if (r_frame_len == 32'd0)
                            bnd = 1'b1;
                        else
                            n_phase = PH_ENCODING;
                    end else begin
                        n_cnt = cnt_eff + 4'd1;
                    end
                end
                PH_ENCODING: begin
                    n_rem = r_frame_len - 32'd1;
                    if (r_frame_len == 32'd1)
                        bnd = 1'b1;
                    else
                        n_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (r_sel_hit) begin
                        o_push            = 1'b1;
                        o_entry.has_text  = 1'b1;
                        o_entry.text_kind = r_sel_kind;
                        o_entry.text_byte = i_data;
                        o_entry.last      = (r_rem == 32'd1);
                    end
                    n_rem = r_rem - 32'd1;
                    if (r_rem == 32'd1)
                        bnd = 1'b1;
                end
                default: begin
                end
            endcase

            if (bnd) begin
                if (reached) begin
                    o_push           = 1'b1;
                    o_entry.has_done = 1'b1;
                    n_phase          = PH_DONE;
                end else begin
                    n_phase = PH_FRAME_HDR;
                    n_cnt   = 4'd0;
                end
            end
        end
        o_entry.offset = n_tag + 29'(id3_pkg::HDR_BYTES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_cnt       <= '0;
            r_tag       <= '0;
            r_consumed  <= '0;
            r_sum       <= '0;
            r_reached   <= 1'b0;
            r_ident     <= '0;
            r_frame_len <= '0;
            r_rem       <= '0;
            r_sync      <= 1'b0;
            r_sel_hit   <= 1'b0;
            r_sel_kind  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_tag       <= n_tag;
            r_consumed  <= n_consumed;
            r_sum       <= n_sum;
            r_reached   <= n_reached;
            r_ident     <= n_ident;
            r_frame_len <= n_frame_len;
            r_rem       <= n_rem;
            r_sync      <= n_sync;
            r_sel_hit   <= n_sel_hit;
            r_sel_kind  <= n_sel_kind;
        end
    end

endmodule

// File: src/id3_fifo.sv
module id3_fifo #(
    parameter int DEPTH = id3_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  id3_pkg::t_entry i_entry,
    output logic            o_room,
    output logic            o_valid,
    output id3_pkg::t_entry o_entry,
    input  logic            i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    id3_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_room  = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push & o_room;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push)
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (do_pop)
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop)
            n_count = r_count + 1'b1;
        else if (!do_push && do_pop)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// File: src/id3_back.sv
module id3_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  id3_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_text,
    output logic            o_last,
    output logic [28:0]     o_offset
);

    logic        r_valid, n_valid;
    logic        r_second, n_second;
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_text, n_text;
    logic        r_last, n_last;
    logic [28:0] r_offset, n_offset;
    logic        load;

    assign load     = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_text   = r_text;
    assign o_last   = r_last;
    assign o_offset = r_offset;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_kind   = r_kind;
        n_text   = r_text;
        n_last   = r_last;
        n_offset = r_offset;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = i_valid;
            if (i_valid) begin
                if (i_entry.has_text && !r_second) begin
                    n_kind   = {1'b0, i_entry.text_kind};
                    n_text   = i_entry.text_byte;
                    n_last   = i_entry.last;
                    n_offset = '0;
                    // a done part behind the text keeps the entry for one more transfer
                    if (i_entry.has_done)
                        n_second = 1'b1;
                    else
                        o_pop = 1'b1;
                end else begin
                    n_kind   = id3_pkg::KIND_DONE;
                    n_text   = '0;
                    n_last   = 1'b0;
                    n_offset = i_entry.offset;
                    n_second = 1'b0;
                    o_pop    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_text   <= n_text;
        r_last   <= n_last;
        r_offset <= n_offset;
    end

endmodule

// File: src/id3_checker.sv
`include "id3v2_text_frame_extractor_defines.svh"

module id3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic        r_rst_n_d;
    logic        first_xfer;
    logic        stall;
    logic [44:0] out_word;
    logic        out_done;
    logic        out_text;
    logic        done_clean;
    logic        text_clean;
    logic        kind_text;

    always_ff @(posedge i_clk) begin
        r_rst_n_d <= i_rst_n;
    end

    // input transfer on the first edge out of reset
    assign first_xfer = s_axis_tvalid & s_axis_tready & !r_rst_n_d;
    assign stall      = m_axis_tvalid & !m_axis_tready;
    assign out_word   = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign out_done   = m_axis_tvalid & (m_axis_tuser == id3_pkg::KIND_DONE);
    assign out_text   = m_axis_tvalid & (m_axis_tuser != id3_pkg::KIND_DONE);
    assign done_clean = !m_axis_tlast && (m_axis_tdata[7:0] == 8'd0);
    assign kind_text  = (m_axis_tuser == id3_pkg::KIND_TITLE)
                     || (m_axis_tuser == id3_pkg::KIND_ARTIST)
                     || (m_axis_tuser == id3_pkg::KIND_ALBUM)
                     || (m_axis_tuser == id3_pkg::KIND_TRACK);
    assign text_clean = (m_axis_tdata[39:8] == 32'd0) && kind_text;

    `ID3_ASSERT(a_out_hold, i_clk, i_rst_n, stall |=> $stable(out_word), "stalled output changed")

    `ID3_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid out of reset")

    `ID3_ASSERT(a_done_shape, i_clk, i_rst_n, out_done |-> done_clean, "done result carries text")

    `ID3_ASSERT(a_text_shape, i_clk, i_rst_n, out_text |-> text_clean, "text result malformed")

    `ID3_ASSERT(a_first_after_reset, i_clk, i_rst_n, first_xfer |=> !m_axis_tvalid, "early result")

endmodule

bind id3v2_text_frame_extractor id3_checker u_id3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
